[design/upst_pkg.sv]
// ----------------------------------------------------------------------------
// upst_pkg
// Shared types and constants of the ultrasonic presence session tracker.
// ----------------------------------------------------------------------------
package upst_pkg;

   localparam int FIELD_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam int DEFAULT_TICK_WIDTH = 16;
   localparam int DEFAULT_RUN_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NEAR_TICK_LIMIT = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FAR_TICK_LIMIT  = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_NEAR_DWELL      = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FAR_DWELL       = 8'd3;

   localparam logic [FIELD_WIDTH-1:0] RESET_NEAR_TICK_LIMIT = 16'd4665;
   localparam logic [FIELD_WIDTH-1:0] RESET_FAR_TICK_LIMIT  = 16'd8163;
   localparam logic [FIELD_WIDTH-1:0] RESET_NEAR_DWELL      = 16'd10;
   localparam logic [FIELD_WIDTH-1:0] RESET_FAR_DWELL       = 16'd2;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] near_tick_limit;
      logic [FIELD_WIDTH-1:0] far_tick_limit;
      logic [FIELD_WIDTH-1:0] near_dwell;
      logic [FIELD_WIDTH-1:0] far_dwell;
   } cfg_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] ticks;
      logic                   is_near;
      logic                   is_far;
   } meas_type;

endpackage

[design/upst_front.sv]
// ----------------------------------------------------------------------------
// upst_front
// Accepts measurement words, computes echo length and near/far class.
// ----------------------------------------------------------------------------
module upst_front #(
   parameter int TICK_WIDTH = upst_pkg::DEFAULT_TICK_WIDTH
) (
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_echo_seen,
   input  logic [upst_pkg::FIELD_WIDTH-1:0] req_edge_start_time,
   input  logic [upst_pkg::FIELD_WIDTH-1:0] req_edge_end_time,
   input  upst_pkg::cfg_type                cfg,
   output logic                             push_valid,
   input  logic                             push_ready,
   output upst_pkg::meas_type               push_word
);
   import upst_pkg::*;

   localparam int CMP_WIDTH = (TICK_WIDTH > FIELD_WIDTH) ? TICK_WIDTH : FIELD_WIDTH;

   logic [TICK_WIDTH-1:0] start_t;
   logic [TICK_WIDTH-1:0] end_t;
   logic [TICK_WIDTH-1:0] ticks;
   logic [CMP_WIDTH-1:0]  ticks_cmp;

   assign start_t   = TICK_WIDTH'(req_edge_start_time);
   assign end_t     = TICK_WIDTH'(req_edge_end_time);
   assign ticks     = end_t - start_t;
   assign ticks_cmp = CMP_WIDTH'(ticks);

   always_comb begin
      push_word.ticks   = req_echo_seen ? FIELD_WIDTH'(ticks) : '0;
      push_word.is_near = req_echo_seen && (ticks_cmp < CMP_WIDTH'(cfg.near_tick_limit));
      push_word.is_far  = !req_echo_seen || (ticks_cmp > CMP_WIDTH'(cfg.far_tick_limit));
   end

   assign push_valid = req_valid;
   assign req_stall  = !push_ready;

endmodule

[design/upst_queue.sv]
// ----------------------------------------------------------------------------
// upst_queue
// Short FIFO of classified measurement words between front and back.
// ----------------------------------------------------------------------------
module upst_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  upst_pkg::meas_type push_word,
   output logic               pop_valid,
   input  logic               pop_ready,
   output upst_pkg::meas_type pop_word
);
   import upst_pkg::*;

   meas_type                   slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic                       push;
   logic                       pop;

   assign push_ready = (count_ff != QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_word   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

[design/upst_back.sv]
// ----------------------------------------------------------------------------
// upst_back
// Session state update: dwell counters, greet/stand-up/sleep events, and
// the registered result word.
// ----------------------------------------------------------------------------
module upst_back #(
   parameter int RUN_WIDTH = upst_pkg::DEFAULT_RUN_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  upst_pkg::cfg_type                cfg,
   input  logic                             pop_valid,
   output logic                             pop_ready,
   input  upst_pkg::meas_type               pop_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [upst_pkg::FIELD_WIDTH-1:0] rsp_echo_ticks,
   output logic                             rsp_is_near,
   output logic                             rsp_is_far,
   output logic                             rsp_greet_event,
   output logic                             rsp_standup_event,
   output logic                             rsp_sleep_event
);
   import upst_pkg::*;

   localparam int CMP_WIDTH = (RUN_WIDTH > FIELD_WIDTH) ? RUN_WIDTH : FIELD_WIDTH;
   localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

   logic                 prev_near_ff, prev_near_in;
   logic                 session_ff, session_in;
   logic [RUN_WIDTH-1:0] near_run_ff, near_run_in;
   logic [RUN_WIDTH-1:0] far_run_ff, far_run_in;
   logic                 standup_done_ff, standup_done_in;
   logic                 sleep_done_ff, sleep_done_in;
   logic                 valid_ff, valid_in;
   meas_type             word_ff;
   logic                 greet_ff, greet_in;
   logic                 standup_ff, standup_in;
   logic                 sleep_ff, sleep_in;
   logic                 take;

   assign pop_ready = !valid_ff || !rsp_stall;
   assign take      = pop_valid && pop_ready;

   always_comb begin
      prev_near_in    = prev_near_ff;
      session_in      = session_ff;
      near_run_in     = near_run_ff;
      far_run_in      = far_run_ff;
      standup_done_in = standup_done_ff;
      sleep_done_in   = sleep_done_ff;
      greet_in        = 1'b0;
      standup_in      = 1'b0;
      sleep_in        = 1'b0;
      valid_in        = valid_ff && rsp_stall;
      if (take) begin
         valid_in     = 1'b1;
         prev_near_in = pop_word.is_near;
         if (pop_word.is_near && !prev_near_ff) begin
            greet_in   = 1'b1;
            session_in = 1'b1;
         end
         if (pop_word.is_near) begin
            near_run_in = (near_run_ff == RUN_MAX) ? RUN_MAX : near_run_ff + 1'b1;
            if (!standup_done_ff && (CMP_WIDTH'(near_run_in) >= CMP_WIDTH'(cfg.near_dwell))) begin
               standup_in      = 1'b1;
               standup_done_in = 1'b1;
            end
            far_run_in    = '0;
            sleep_done_in = 1'b0;
         end else begin
            near_run_in     = '0;
            standup_done_in = 1'b0;
            if (session_ff && pop_word.is_far) begin
               far_run_in = (far_run_ff == RUN_MAX) ? RUN_MAX : far_run_ff + 1'b1;
               if (!sleep_done_ff && (CMP_WIDTH'(far_run_in) >= CMP_WIDTH'(cfg.far_dwell))) begin
                  sleep_in      = 1'b1;
                  sleep_done_in = 1'b1;
                  session_in    = 1'b0;
               end
            end else begin
               far_run_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_near_ff    <= 1'b0;
         session_ff      <= 1'b0;
         near_run_ff     <= '0;
         far_run_ff      <= '0;
         standup_done_ff <= 1'b0;
         sleep_done_ff   <= 1'b0;
         valid_ff        <= 1'b0;
      end else begin
         prev_near_ff    <= prev_near_in;
         session_ff      <= session_in;
         near_run_ff     <= near_run_in;
         far_run_ff      <= far_run_in;
         standup_done_ff <= standup_done_in;
         sleep_done_ff   <= sleep_done_in;
         valid_ff        <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff    <= pop_word;
         greet_ff   <= greet_in;
         standup_ff <= standup_in;
         sleep_ff   <= sleep_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_echo_ticks    = word_ff.ticks;
   assign rsp_is_near       = word_ff.is_near;
   assign rsp_is_far        = word_ff.is_far;
   assign rsp_greet_event   = greet_ff;
   assign rsp_standup_event = standup_ff;
   assign rsp_sleep_event   = sleep_ff;

   a_sleep_closes: assert property (@(posedge clock) disable iff (reset)
      take && sleep_in |=> !session_ff && rsp_sleep_event)
      else $error("sleep event left session open");

   a_greet_opens: assert property (@(posedge clock) disable iff (reset)
      take && greet_in |=> session_ff && prev_near_ff)
      else $error("greet event did not open session");

   a_standup_near: assert property (@(posedge clock) disable iff (reset)
      valid_ff && standup_ff |-> word_ff.is_near && standup_done_ff)
      else $error("stand-up event without near measurement");

   a_no_greet_and_sleep: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !(greet_ff && sleep_ff))
      else $error("greet and sleep in one result");

endmodule

[design/ultrasonic_presence_session_tracker.sv]
// ----------------------------------------------------------------------------
// ultrasonic_presence_session_tracker
// Presence tracker for ultrasonic echo measurements with session events.
// ----------------------------------------------------------------------------
// One measurement word is taken per clock while the queue has room, and one
// result word comes out per measurement. The result word passes through the
// queue and the result register before it is presented. The front classifies
// the echo length against the tick limits in the accept cycle, a two-entry
// queue holds classified words, and the back does the dwell counter and
// session update into the result register. The user must write registers
// through the csr_ port only while the block is idle; the block itself does
// not enforce this. Indexes beyond the register list are ignored.
module ultrasonic_presence_session_tracker #(
   parameter int TICK_WIDTH = upst_pkg::DEFAULT_TICK_WIDTH,
   parameter int RUN_WIDTH  = upst_pkg::DEFAULT_RUN_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_echo_seen,
   input  logic [upst_pkg::FIELD_WIDTH-1:0]     req_edge_start_time,
   input  logic [upst_pkg::FIELD_WIDTH-1:0]     req_edge_end_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [upst_pkg::FIELD_WIDTH-1:0]     rsp_echo_ticks,
   output logic                                 rsp_is_near,
   output logic                                 rsp_is_far,
   output logic                                 rsp_greet_event,
   output logic                                 rsp_standup_event,
   output logic                                 rsp_sleep_event,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [upst_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [upst_pkg::FIELD_WIDTH-1:0]     csr_data
);
   import upst_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     push_valid;
   logic     push_ready;
   meas_type push_word;
   logic     pop_valid;
   logic     pop_ready;
   meas_type pop_word;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_NEAR_TICK_LIMIT: cfg_in.near_tick_limit = csr_data;
            REG_FAR_TICK_LIMIT:  cfg_in.far_tick_limit  = csr_data;
            REG_NEAR_DWELL:      cfg_in.near_dwell      = csr_data;
            REG_FAR_DWELL:       cfg_in.far_dwell       = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_tick_limit <= RESET_NEAR_TICK_LIMIT;
         cfg_ff.far_tick_limit  <= RESET_FAR_TICK_LIMIT;
         cfg_ff.near_dwell      <= RESET_NEAR_DWELL;
         cfg_ff.far_dwell       <= RESET_FAR_DWELL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   upst_front #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_front (
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_echo_seen       (req_echo_seen),
      .req_edge_start_time (req_edge_start_time),
      .req_edge_end_time   (req_edge_end_time),
      .cfg                 (cfg_ff),
      .push_valid          (push_valid),
      .push_ready          (push_ready),
      .push_word           (push_word)
   );

   upst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word)
   );

   upst_back #(
      .RUN_WIDTH (RUN_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_word          (pop_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_echo_ticks    (rsp_echo_ticks),
      .rsp_is_near       (rsp_is_near),
      .rsp_is_far        (rsp_is_far),
      .rsp_greet_event   (rsp_greet_event),
      .rsp_standup_event (rsp_standup_event),
      .rsp_sleep_event   (rsp_sleep_event)
   );

endmodule
